>>> hw/rtl/dtq_pkg.sv
package dtq_pkg;

	localparam int unsigned DefEntries = 16;
	localparam int unsigned MaxResults = 16;

	typedef enum logic [1:0] {
		ACT_ADD_ONE  = 2'd0,
		ACT_ADD_PER  = 2'd1,
		ACT_CANCEL   = 2'd2,
		ACT_TICK     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_ADDED   = 2'd0,
		KIND_FULL    = 2'd1,
		KIND_EXPIRED = 2'd2,
		KIND_UNUSED  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now;
		logic [31:0] delay;
		logic [31:0] cancel_id;
		logic [31:0] user_tag;
		logic        notify;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] res_id;
		logic [31:0] tag_out;
		logic        notify_out;
		logic        last;
	} out_item_t;

	// Saturating unsigned add of two millisecond times.
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

>>> hw/rtl/deadline_timer_queue_top.sv
// Deadline timer queue.
// The command channel (cmd_valid/cmd_ready/cmd_data) carries add, cancel and
// tick commands; the response channel (rsp_valid/rsp_ready/rsp_data) returns
// results. An add answers with one transaction holding the new id, or a
// refusal when every slot is busy. A cancel returns nothing. A tick returns one
// transaction per expired timer, in deadline order (ties oldest first), at most
// 16, with last set on the final one.
// Timer entries live in a synchronous memory with a registered read port.
// An add is answered from the valid bits without a scan: its result goes to
// the holding register and from there to the output register, and the next
// command is taken once it has moved on. A cancel scans all ENTRIES slots and
// keeps the input closed until the scan and its action are done. A tick scans
// the table again after each fired timer, save after the sixteenth.
// Reset clears all valid bits, the id counter to one and the insertion counter
// to zero; no clearing pass is needed.
// When the receiver stalls, the pending result waits in a holding register,
// a tick waits before firing its next timer, and no new command is taken until the current one is done.
module deadline_timer_queue_top #(
	parameter int unsigned ENTRIES = dtq_pkg::DefEntries
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  dtq_pkg::in_item_t  cmd_data,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output dtq_pkg::out_item_t rsp_data
);
	import dtq_pkg::*;

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned NW = $clog2(MaxResults + 1);

	typedef struct packed {
		logic [31:0] deadline;
		logic [31:0] period;
		logic [31:0] id;
		logic [31:0] tag;
		logic        notify;
		logic [31:0] order;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_WRITE,
		ST_OUT
	} state_t;

	slot_t           mem [ENTRIES];
	slot_t           rd_s1;
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] fired_q;

	state_t          state_q;
	in_item_t        cmd_q;
	logic [31:0]     next_id_q;
	logic [31:0]     order_q;
	logic [CW-1:0]   addr_q;
	logic [IW-1:0]   rd_idx_s1;
	logic            rd_ok_s1;
	logic            best_ok_q;
	logic [IW-1:0]   best_idx_q;
	slot_t           best_q;
	logic [NW-1:0]   nfired_q;
	out_item_t       out_q;
	logic            out_valid_q;
	logic            pend_q;
	out_item_t       pend_data_q;

	logic            we;
	logic [IW-1:0]   wa;
	slot_t           wd;
	logic            out_load;

	// Candidate check of the slot just read.
	logic            cand;
	logic            earlier;
	logic            scan_done;

	always_comb begin
		earlier = (rd_s1.deadline < best_q.deadline) ||
			((rd_s1.deadline == best_q.deadline) &&
			 ((order_q - rd_s1.order) > (order_q - best_q.order)));
		cand = 1'b0;
		if (rd_ok_s1 && valid_q[rd_idx_s1]) begin
			if (cmd_q.action == ACT_CANCEL) begin
				cand = (rd_s1.id == cmd_q.cancel_id);
			end else begin
				cand = !fired_q[rd_idx_s1] && (rd_s1.deadline <= cmd_q.now);
			end
		end
		scan_done = (addr_q == CW'(ENTRIES)) && !rd_ok_s1;
	end

	// Lowest free slot, over valid bits held in flip-flops.
	logic            free_ok;
	logic [IW-1:0]   free_idx;
	always_comb begin
		free_ok = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// Slot memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_s1 <= mem[addr_q[IW-1:0]];
		rd_idx_s1 <= addr_q[IW-1:0];
	end

	// Write port contents for adds and re-arms.
	always_comb begin
		we = 1'b0;
		wa = best_idx_q;
		wd = best_q;
		if (state_q == ST_IDLE && cmd_valid && cmd_ready &&
		    (cmd_data.action == ACT_ADD_ONE || cmd_data.action == ACT_ADD_PER) && free_ok) begin
			we = 1'b1;
			wa = free_idx;
			wd.deadline = sat_add(cmd_data.now, cmd_data.delay);
			wd.period = (cmd_data.action == ACT_ADD_PER) ? cmd_data.delay : 32'd0;
			wd.id = next_id_q;
			wd.tag = cmd_data.user_tag;
			wd.notify = cmd_data.notify;
			wd.order = order_q;
		end else if (state_q == ST_WRITE && best_q.period != 32'd0) begin
			we = 1'b1;
			wd.deadline = sat_add(cmd_q.now, best_q.period);
			wd.order = order_q;
		end
	end

	assign cmd_ready = (state_q == ST_IDLE) && !pend_q;

	// The held result moves to the output register when that register is free.
	assign out_load = (state_q == ST_OUT || (state_q == ST_IDLE && pend_q)) &&
		(!out_valid_q || rsp_ready);

	// Controller: command capture, scans, and result output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			fired_q <= '0;
			next_id_q <= 32'd1;
			order_q <= '0;
			addr_q <= '0;
			rd_ok_s1 <= 1'b0;
			best_ok_q <= 1'b0;
			nfired_q <= '0;
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q <= pend_data_q;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_ok_s1 <= (state_q == ST_SCAN) && (addr_q != CW'(ENTRIES));
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						cmd_q <= cmd_data;
						if (cmd_data.action == ACT_ADD_ONE || cmd_data.action == ACT_ADD_PER) begin
							pend_q <= 1'b1;
							if (free_ok) begin
								valid_q[free_idx] <= 1'b1;
								order_q <= order_q + 32'd1;
								next_id_q <= (next_id_q == 32'hFFFF_FFFF) ? 32'd1 :
									next_id_q + 32'd1;
								pend_data_q <= '{kind: KIND_ADDED, res_id: next_id_q,
									tag_out: 32'd0, notify_out: 1'b0, last: 1'b1};
							end else begin
								pend_data_q <= '{kind: KIND_FULL, res_id: 32'd0,
									tag_out: 32'd0, notify_out: 1'b0, last: 1'b1};
							end
						end else begin
							fired_q <= '0;
							nfired_q <= '0;
							addr_q <= '0;
							best_ok_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end else if (pend_q && out_load) begin
						// Add answers go from the holding register to the output register.
						pend_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (addr_q != CW'(ENTRIES)) begin
						addr_q <= addr_q + CW'(1);
					end
					if (cand && (!best_ok_q || earlier)) begin
						best_ok_q <= 1'b1;
						best_idx_q <= rd_idx_s1;
						best_q <= rd_s1;
					end
					if (scan_done) begin
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					if (cmd_q.action == ACT_CANCEL) begin
						if (best_ok_q) begin
							valid_q[best_idx_q] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end else if (!best_ok_q) begin
						// Nothing more due: mark the previous result as last.
						if (nfired_q != '0) begin
							pend_data_q.last <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (nfired_q == '0) begin
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Send the held result of the previous pick.
					if (out_load) begin
						if (pend_data_q.last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					fired_q[best_idx_q] <= 1'b1;
					if (best_q.period != 32'd0) begin
						order_q <= order_q + 32'd1;
					end else begin
						valid_q[best_idx_q] <= 1'b0;
					end
					pend_data_q <= '{kind: KIND_EXPIRED, res_id: best_q.id,
						tag_out: best_q.tag, notify_out: best_q.notify,
						last: (nfired_q == NW'(MaxResults - 1))};
					nfired_q <= nfired_q + NW'(1);
					if (nfired_q == NW'(MaxResults - 1)) begin
						state_q <= ST_OUT;
					end else begin
						addr_q <= '0;
						best_ok_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data = out_q;

endmodule

>>> hw/rtl/dtq_checker.sv
module dtq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input dtq_pkg::in_item_t  cmd_data,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input dtq_pkg::out_item_t rsp_data
);
	import dtq_pkg::*;

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("output changed while stalled");

	// Add answers never carry a tag or callback flag.
	a_add_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.kind == KIND_ADDED || rsp_data.kind == KIND_FULL) |->
		rsp_data.last && rsp_data.tag_out == 32'd0 && !rsp_data.notify_out)
		else $error("malformed add answer");

	// Refusals carry id zero, accepted adds a nonzero id.
	a_add_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.kind == KIND_FULL) == (rsp_data.res_id == 32'd0) ||
		rsp_data.kind == KIND_EXPIRED)
		else $error("bad id on add answer");

	// The unused kind code never appears.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.kind != KIND_UNUSED)
		else $error("illegal result kind");

endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (.*);

>>> tb/deadline_timer_queue_checker.sv
module deadline_timer_queue_checker #(
	parameter int unsigned ENTRIES = dtq_pkg::DefEntries
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_ready,
	input  dtq_pkg::in_item_t  cmd_data,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  dtq_pkg::out_item_t rsp_data,
	output int                 fail_count,
	output int                 pending_count
);
	import dtq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Model copy of the timer table.
	logic        tmr_live [ENTRIES];
	logic [31:0] tmr_due [ENTRIES];
	logic [31:0] tmr_period [ENTRIES];
	logic [31:0] tmr_id [ENTRIES];
	logic [31:0] tmr_tag [ENTRIES];
	logic        tmr_notify [ENTRIES];
	logic [31:0] tmr_seq [ENTRIES];
	logic [31:0] id_counter;
	logic [31:0] seq_counter;

	out_item_t expected_results[$];

	function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// True when entry a is to fire ahead of entry b.
	function automatic bit ahead_of(int a, int b);
		if (tmr_due[a] != tmr_due[b]) begin
			return tmr_due[a] < tmr_due[b];
		end
		return (seq_counter - tmr_seq[a]) > (seq_counter - tmr_seq[b]);
	endfunction

	// Apply one command to the table and queue the results it causes.
	task automatic apply_command(in_item_t cmd);
		int free_idx;
		int hit;
		int best;
		int fired;
		bit due_now [ENTRIES];
		out_item_t res;
		free_idx = -1;
		hit = -1;
		fired = 0;
		res = '0;
		case (action_t'(cmd.action))
			ACT_ADD_ONE, ACT_ADD_PER: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (!tmr_live[i] && free_idx < 0) free_idx = i;
				end
				res.last = 1'b1;
				if (free_idx < 0) begin
					res.kind = KIND_FULL;
				end else begin
					tmr_live[free_idx] = 1'b1;
					tmr_due[free_idx] = add_sat(cmd.now, cmd.delay);
					tmr_period[free_idx] = (cmd.action == ACT_ADD_PER) ? cmd.delay : '0;
					tmr_id[free_idx] = id_counter;
					tmr_tag[free_idx] = cmd.user_tag;
					tmr_notify[free_idx] = cmd.notify;
					tmr_seq[free_idx] = seq_counter;
					seq_counter++;
					res.kind = KIND_ADDED;
					res.res_id = id_counter;
					id_counter++;
					if (id_counter == 0) id_counter = 1;
				end
				expected_results.push_back(res);
			end
			ACT_CANCEL: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (tmr_live[i] && tmr_id[i] == cmd.cancel_id &&
						(hit < 0 || ahead_of(i, hit))) hit = i;
				end
				if (hit >= 0) tmr_live[hit] = 1'b0;
			end
			default: begin
				for (int i = 0; i < ENTRIES; i++) begin
					due_now[i] = tmr_live[i] && tmr_due[i] <= cmd.now;
				end
				while (fired < MaxResults) begin
					best = -1;
					for (int i = 0; i < ENTRIES; i++) begin
						if (due_now[i] && (best < 0 || ahead_of(i, best))) best = i;
					end
					if (best < 0) break;
					due_now[best] = 1'b0;
					res = '0;
					res.kind = KIND_EXPIRED;
					res.res_id = tmr_id[best];
					res.tag_out = tmr_tag[best];
					res.notify_out = tmr_notify[best];
					expected_results.push_back(res);
					fired++;
					if (tmr_period[best] != 0) begin
						tmr_due[best] = add_sat(cmd.now, tmr_period[best]);
						tmr_seq[best] = seq_counter;
						seq_counter++;
					end else begin
						tmr_live[best] = 1'b0;
					end
				end
				if (fired > 0) expected_results[$].last = 1'b1;
			end
		endcase
	endtask

	// Watch both channels at each edge.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) tmr_live[i] = 1'b0;
			id_counter = 32'd1;
			seq_counter = '0;
			fail_count <= 0;
			expected_results.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.kind != rsp_data.kind || want.res_id != rsp_data.res_id ||
						want.tag_out != rsp_data.tag_out ||
						want.notify_out != rsp_data.notify_out ||
						want.last != rsp_data.last) begin
						$display("%0t: mismatch, expected %p, actual %p", $time, want, rsp_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cmd_valid && cmd_ready) apply_command(cmd_data);
		end
		pending_count = expected_results.size();
	end
endmodule

>>> tb/deadline_timer_queue_top_tb.sv
module deadline_timer_queue_top_tb;
	import dtq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	in_item_t  cmd_data;
	logic      rsp_valid;
	logic      rsp_ready;
	out_item_t rsp_data;
	int        fail_count;
	int        pending_count;
	bit        hold_off;

	// Ids handed out so far, tracked loosely for cancel targets.
	logic [31:0] issued_ids = 32'd1;
	logic [31:0] clock_ms = '0;

	deadline_timer_queue_top uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
	);

	deadline_timer_queue_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Send one command transaction and wait for its acceptance.
	task automatic send_command(action_t act, logic [31:0] now_ms, logic [31:0] dly,
		logic [31:0] cid, logic [31:0] tag, logic ntf);
		in_item_t cmd;
		cmd.action = act;
		cmd.now = now_ms;
		cmd.delay = dly;
		cmd.cancel_id = cid;
		cmd.user_tag = tag;
		cmd.notify = ntf;
		cmd_valid <= 1'b1;
		cmd_data <= cmd;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		if (act == ACT_ADD_ONE || act == ACT_ADD_PER) issued_ids = issued_ids + 1;
	endtask

	task automatic idle_sender(int n);
		if (n > 0) begin
			cmd_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Random command, mostly well-formed traffic on a rising clock.
	task automatic random_command(bit no_gaps);
		int r;
		logic [31:0] dly;
		r = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: dly = '0;
			1: dly = 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: dly = $urandom;
			default: dly = $urandom_range(1, 200);
		endcase
		if ($urandom_range(0, 3) == 0) clock_ms = clock_ms + $urandom_range(0, 150);
		if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
		if (r < 30) begin
			send_command(ACT_ADD_ONE, clock_ms, dly, $urandom, $urandom,
				1'($urandom_range(0, 1)));
		end else if (r < 55) begin
			send_command(ACT_ADD_PER, clock_ms, dly, $urandom, $urandom,
				1'($urandom_range(0, 1)));
		end else if (r < 70) begin
			send_command(ACT_CANCEL, clock_ms, $urandom,
				($urandom_range(0, 4) == 0) ? $urandom : issued_ids - $urandom_range(1, 12),
				$urandom, 1'($urandom_range(0, 1)));
		end else begin
			send_command(ACT_TICK, clock_ms, $urandom, $urandom, $urandom,
				1'($urandom_range(0, 1)));
		end
		if (!no_gaps) idle_sender(gap_len());
	endtask

	// Receiver: random stalls, with one long hold-off when requested.
	initial begin
		int n;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				rsp_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			n = gap_len();
			if (n > 0) begin
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		int t;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_data = '0;
		hold_off = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: saturation, zero period, empty tick, full table, cancels.
		send_command(ACT_TICK, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		send_command(ACT_ADD_ONE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);
		send_command(ACT_ADD_PER, 32'd0, 32'd0, 32'd0, 32'hA5A5_5A5A, 1'b0);
		send_command(ACT_ADD_PER, 32'hFFFF_FFFE, 32'd5, 32'd0, 32'h1234_5678, 1'b1);
		for (int i = 0; i < 15; i++) begin
			send_command(i[0] ? ACT_ADD_PER : ACT_ADD_ONE, 32'd10, 32'd5, 32'd0, 32'(i), i[1]);
		end
		send_command(ACT_CANCEL, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		send_command(ACT_CANCEL, 32'd0, 32'd0, 32'd4, 32'd0, 1'b0);
		send_command(ACT_CANCEL, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
		send_command(ACT_TICK, 32'd15, 32'd0, 32'd0, 32'd0, 1'b0);
		send_command(ACT_TICK, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b1);
		send_command(ACT_TICK, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b1);

		// Random traffic with one long receiver hold-off in the middle.
		clock_ms = 32'd100;
		for (int i = 0; i < 300; i++) begin
			if (i == 120) hold_off = 1'b1;
			random_command(i >= 120 && i < 160);
		end
		cmd_valid <= 1'b0;

		t = 0;
		while (pending_count != 0 && t < 200000) begin
			@(posedge clk);
			t++;
		end
		repeat (600) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

>>> deadline_timer_queue_top.f
hw/rtl/dtq_pkg.sv
hw/rtl/deadline_timer_queue_top.sv
hw/rtl/dtq_checker.sv
tb/deadline_timer_queue_checker.sv
tb/deadline_timer_queue_top_tb.sv
